// ----- rtl/mcr_pkg.sv -----
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants of the midpoint circle raster core.
// ----------------------------------------------------------------------------
package mcr_pkg;

   // Request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   // Register map: word index taken from paddr[2]
   localparam int  ADDR_W         = 3;
   localparam int  DATA_W         = 32;
   localparam int  FRAME_W        = 11;
   localparam logic REG_FRAME_ROWS = 1'b0;
   localparam logic REG_FRAME_COLS = 1'b1;
   localparam logic [FRAME_W-1:0] FRAME_RESET = 11'd512;

   // Decision value constants
   localparam int DEC_START    = 3;
   localparam int DEC_INC_KEEP = 6;
   localparam int DEC_INC_DIAG = 10;

   // Eight-way symmetry: point k negates the row or column offset when bit k is set
   localparam int PT_W = 3;
   localparam logic [7:0] ROW_NEG = 8'b1110_0100;
   localparam logic [7:0] COL_NEG = 8'b1101_1000;
   localparam logic [PT_W-1:0] PT_LAST = 3'd7;

   typedef struct packed {
      logic done_only;    // step after completion: one empty result
      logic circle_done;  // circle complete after this item
   } mcr_ctrl_type;

endpackage

// ----- rtl/midpoint_circle_raster_core.sv -----
// ----------------------------------------------------------------------------
// midpoint_circle_raster_core
// Midpoint circle generator with eight-way symmetry and frame clipping.
// ----------------------------------------------------------------------------
// A start item (req_type 0) loads centre, radius and colour and yields the
// eight mirrored points of (0, radius); each step item (req_type 1) advances
// the midpoint decision one column and yields eight more points, the last
// flagged with rsp_is_last and, once x passes y, rsp_circle_done. A step after
// the circle is complete yields a single empty result with both flags set.
// Points outside rows [0, frame_rows) or columns [0, frame_cols) come out with
// rsp_visible low and zero coordinates. The point generator drives one result
// per cycle while rsp_ready takes them: eight results for a start or step item
// and one for a step after completion. The front end updates the decision in
// the accept cycle and pushes a job into a two-entry queue; the job being
// walked keeps its entry until its last point is loaded, so one more job can
// wait behind it and req_ready drops while both entries are taken. The first
// result passes through the job queue and then the result register.
// Frame registers sit at byte addresses 0 (rows) and 4 (columns), reset to
// 512, and must be written only while idle.
// ----------------------------------------------------------------------------
module midpoint_circle_raster_core #(
   parameter int COORD_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [COORD_BITS-1:0]         req_center_row,
   input  logic [COORD_BITS-1:0]         req_center_col,
   input  logic [COORD_BITS-1:0]         req_radius,
   input  logic [23:0]                   req_draw_color,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [COORD_BITS-1:0]         rsp_pixel_row,
   output logic [COORD_BITS-1:0]         rsp_pixel_col,
   output logic [23:0]                   rsp_pixel_color,
   output logic                          rsp_visible,
   output logic                          rsp_is_last,
   output logic                          rsp_circle_done,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mcr_pkg::ADDR_W-1:0]    paddr,
   input  logic [mcr_pkg::DATA_W-1:0]    pwdata,
   output logic [mcr_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);
   import mcr_pkg::*;

   localparam int XW = COORD_BITS + 1;
   localparam int QW = 2 * COORD_BITS + 2 * XW + 24 + $bits(mcr_ctrl_type);

   // Frame registers
   logic [FRAME_W-1:0] rows_ff, rows_in;
   logic [FRAME_W-1:0] cols_ff, cols_in;
   logic               wr_en;

   // Front to queue
   logic                  push, q_full;
   logic [COORD_BITS-1:0] f_r0, f_c0;
   logic signed [XW-1:0]  f_x, f_y;
   logic [23:0]           f_color;
   mcr_ctrl_type          f_ctrl;

   // Queue to back
   logic                  q_valid, q_pop;
   logic [QW-1:0]         q_data;
   logic [COORD_BITS-1:0] b_r0, b_c0;
   logic signed [XW-1:0]  b_x, b_y;
   logic [23:0]           b_color;
   mcr_ctrl_type          b_ctrl;

   // Register write: word select on paddr[2], low bits ignored
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      prdata  = '0;
      unique case (paddr[2])
         REG_FRAME_ROWS: begin
            prdata = DATA_W'(rows_ff);
            if (wr_en) begin
               rows_in = pwdata[FRAME_W-1:0];
            end
         end
         REG_FRAME_COLS: begin
            prdata = DATA_W'(cols_ff);
            if (wr_en) begin
               cols_in = pwdata[FRAME_W-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= FRAME_RESET;
         cols_ff <= FRAME_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // Front: accept, update decision, queue a job
   mcr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_center_row (req_center_row),
      .req_center_col (req_center_col),
      .req_radius     (req_radius),
      .req_draw_color (req_draw_color),
      .queue_full     (q_full),
      .job_push       (push),
      .job_r0         (f_r0),
      .job_c0         (f_c0),
      .job_x          (f_x),
      .job_y          (f_y),
      .job_color      (f_color),
      .job_ctrl       (f_ctrl)
   );

   // Two-entry job queue decouples accept from point output
   mcr_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_ctrl, f_color, f_y, f_x, f_c0, f_r0}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_data)
   );

   assign {b_ctrl, b_color, b_y, b_x, b_c0, b_r0} = q_data;

   // Back: one mirrored point per cycle into the result register unless rsp_ready stalls it
   mcr_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (q_valid),
      .job_pop         (q_pop),
      .job_r0          (b_r0),
      .job_c0          (b_c0),
      .job_x           (b_x),
      .job_y           (b_y),
      .job_color       (b_color),
      .job_ctrl        (b_ctrl),
      .frame_rows      (rows_ff),
      .frame_cols      (cols_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_pixel_col   (rsp_pixel_col),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_visible     (rsp_visible),
      .rsp_is_last     (rsp_is_last),
      .rsp_circle_done (rsp_circle_done)
   );

endmodule

// ----- rtl/mcr_fifo.sv -----
// ----------------------------------------------------------------------------
// mcr_fifo
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module mcr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/mcr_front.sv -----
// ----------------------------------------------------------------------------
// mcr_front
// Accepts requests, runs the midpoint decision update and queues one job
// per item for the point generator.
// ----------------------------------------------------------------------------
module mcr_front #(
   parameter int COORD_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_type,
   input  logic [COORD_BITS-1:0]    req_center_row,
   input  logic [COORD_BITS-1:0]    req_center_col,
   input  logic [COORD_BITS-1:0]    req_radius,
   input  logic [23:0]              req_draw_color,
   input  logic                     queue_full,
   output logic                     job_push,
   output logic [COORD_BITS-1:0]    job_r0,
   output logic [COORD_BITS-1:0]    job_c0,
   output logic signed [COORD_BITS:0] job_x,
   output logic signed [COORD_BITS:0] job_y,
   output logic [23:0]              job_color,
   output mcr_pkg::mcr_ctrl_type    job_ctrl
);
   import mcr_pkg::*;

   localparam int XW = COORD_BITS + 1;
   localparam int DW = COORD_BITS + 5;

   logic [COORD_BITS-1:0] r0_ff, r0_in;
   logic [COORD_BITS-1:0] c0_ff, c0_in;
   logic [23:0]           color_ff, color_in;
   logic signed [XW-1:0]  x_ff, x_in;
   logic signed [XW-1:0]  y_ff, y_in;
   logic signed [DW-1:0]  dec_ff, dec_in;
   logic                  fin_ff, fin_in;
   mcr_ctrl_type          ctrl;
   logic                  accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      r0_in    = r0_ff;
      c0_in    = c0_ff;
      color_in = color_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      dec_in   = dec_ff;
      fin_in   = fin_ff;
      ctrl     = '{done_only: 1'b0, circle_done: 1'b0};
      unique case (req_type)
         REQ_START: begin
            r0_in    = req_center_row;
            c0_in    = req_center_col;
            color_in = req_draw_color;
            x_in     = '0;
            y_in     = XW'(req_radius);
            dec_in   = DW'(DEC_START) - (DW'(req_radius) << 1);
            fin_in   = 1'b0;
         end
         REQ_STEP: begin
            if (fin_ff) begin
               ctrl = '{done_only: 1'b1, circle_done: 1'b1};
            end else begin
               if (dec_ff[DW-1]) begin
                  dec_in = dec_ff + (DW'(x_ff) << 2) + DW'(DEC_INC_KEEP);
               end else begin
                  dec_in = dec_ff + ((DW'(x_ff) - DW'(y_ff)) << 2) + DW'(DEC_INC_DIAG);
                  y_in   = y_ff - XW'(1);
               end
               x_in   = x_ff + XW'(1);
               fin_in = (x_in > y_in);
               ctrl   = '{done_only: 1'b0, circle_done: fin_in};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= 1'b1;
      end else if (accept) begin
         fin_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         r0_ff    <= r0_in;
         c0_ff    <= c0_in;
         color_ff <= color_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         dec_ff   <= dec_in;
      end
   end

   assign job_push  = accept;
   assign job_r0    = r0_in;
   assign job_c0    = c0_in;
   assign job_x     = x_in;
   assign job_y     = y_in;
   assign job_color = color_in;
   assign job_ctrl  = ctrl;

endmodule

// ----- rtl/mcr_back.sv -----
// ----------------------------------------------------------------------------
// mcr_back
// Walks the eight mirrored points of a queued job (one empty point for a
// done-only job), clips each against the frame and registers the result.
// ----------------------------------------------------------------------------
module mcr_back #(
   parameter int COORD_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   output logic                          job_pop,
   input  logic [COORD_BITS-1:0]         job_r0,
   input  logic [COORD_BITS-1:0]         job_c0,
   input  logic signed [COORD_BITS:0]    job_x,
   input  logic signed [COORD_BITS:0]    job_y,
   input  logic [23:0]                   job_color,
   input  mcr_pkg::mcr_ctrl_type         job_ctrl,
   input  logic [mcr_pkg::FRAME_W-1:0]   frame_rows,
   input  logic [mcr_pkg::FRAME_W-1:0]   frame_cols,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [COORD_BITS-1:0]         rsp_pixel_row,
   output logic [COORD_BITS-1:0]         rsp_pixel_col,
   output logic [23:0]                   rsp_pixel_color,
   output logic                          rsp_visible,
   output logic                          rsp_is_last,
   output logic                          rsp_circle_done
);
   import mcr_pkg::*;

   localparam int CW = (COORD_BITS + 2 > FRAME_W + 1) ? COORD_BITS + 2 : FRAME_W + 1;

   logic [PT_W-1:0]       idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [23:0]           color_ff, color_in;
   logic                  vis_ff, vis_in;
   logic                  last_ff, last_in;
   logic                  done_ff, done_in;

   logic                  load;
   logic signed [COORD_BITS:0] row_op, col_op;
   logic signed [CW-1:0]  r0_w, c0_w, row_w, col_w;
   logic signed [CW-1:0]  rows_w, cols_w, cap_w;

   assign load    = job_valid && (!valid_ff || rsp_ready);
   assign job_pop = load && last_in;

   always_comb begin
      row_op = idx_ff[0] ? job_y : job_x;
      col_op = idx_ff[0] ? job_x : job_y;
      r0_w   = CW'(job_r0);
      c0_w   = CW'(job_c0);
      row_w  = ROW_NEG[idx_ff] ? r0_w - CW'(row_op) : r0_w + CW'(row_op);
      col_w  = COL_NEG[idx_ff] ? c0_w - CW'(col_op) : c0_w + CW'(col_op);
      rows_w = CW'(frame_rows);
      cols_w = CW'(frame_cols);
      cap_w  = CW'(1) << COORD_BITS;
      vis_in = !row_w[CW-1] && !col_w[CW-1] && (row_w < rows_w) && (row_w < cap_w)
               && (col_w < cols_w) && (col_w < cap_w);
      if (job_ctrl.done_only) begin
         vis_in = 1'b0;
      end
      row_in   = vis_in ? row_w[COORD_BITS-1:0] : '0;
      col_in   = vis_in ? col_w[COORD_BITS-1:0] : '0;
      color_in = job_ctrl.done_only ? '0 : job_color;
      last_in  = job_ctrl.done_only || (idx_ff == PT_LAST);
      done_in  = job_ctrl.circle_done;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = last_in ? '0 : idx_ff + PT_W'(1);
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         color_ff <= color_in;
         vis_ff   <= vis_in;
         last_ff  <= last_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_row   = row_ff;
   assign rsp_pixel_col   = col_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_visible     = vis_ff;
   assign rsp_is_last     = last_ff;
   assign rsp_circle_done = done_ff;

endmodule

// ----- rtl/mcr_checker.sv -----
// ----------------------------------------------------------------------------
// mcr_checker
// Port-level checks on the midpoint circle raster core.
// ----------------------------------------------------------------------------
module mcr_checker #(
   parameter int COORD_BITS = 10
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] rsp_pixel_row,
   input logic [COORD_BITS-1:0] rsp_pixel_col,
   input logic [23:0]           rsp_pixel_color,
   input logic                  rsp_visible,
   input logic                  rsp_is_last,
   input logic                  rsp_circle_done
);

   // Reset drops any pending result
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_row)
      && $stable(rsp_pixel_col) && $stable(rsp_pixel_color)
      && $stable(rsp_visible) && $stable(rsp_is_last) && $stable(rsp_circle_done))
      else $error("stalled result changed");

   // Clipped points carry zero coordinates
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_pixel_row == '0 && rsp_pixel_col == '0)
      else $error("invisible point with nonzero coordinates");

   // Points of one item leave without gaps until the last one
   a_item_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_is_last |=> rsp_valid)
      else $error("gap inside the points of one item");

endmodule

bind midpoint_circle_raster_core mcr_checker #(.COORD_BITS(COORD_BITS)) u_mcr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pixel_row   (rsp_pixel_row),
   .rsp_pixel_col   (rsp_pixel_col),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_visible     (rsp_visible),
   .rsp_is_last     (rsp_is_last),
   .rsp_circle_done (rsp_circle_done)
);
